FILE: hdl/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants for the register read sequencer
// Phase and step codes, bus command and job formats, message characters and
// the byte-to-decimal helper used when a message job is built.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_X_REGISTER     = 2'd1;
  localparam logic [1:0] CFG_Y_REGISTER     = 2'd2;

  // Configuration reset values
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd28;
  localparam logic [7:0] X_REGISTER_RST     = 8'd41;
  localparam logic [7:0] Y_REGISTER_RST     = 8'd43;

  // Default depth of the job queue between front and back end
  localparam int RRS_QUEUE_DEPTH = 2;

  // Digits per value in the message
  localparam int DECIMAL_DIGITS = 3;

  // Message characters
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_X    = 8'h58;
  localparam logic [7:0] CHAR_Y    = 8'h59;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  // Transfer phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WRITING = 2'd1,
    PH_READING = 2'd2
  } phase_t;

  // Step within a register read
  typedef enum logic [2:0] {
    STP_START    = 3'd0,
    STP_ADDR_W   = 3'd1,
    STP_REG_SENT = 3'd2,
    STP_RESTART  = 3'd3,
    STP_ADDR_R   = 3'd4,
    STP_DATA     = 3'd5
  } step_t;

  // One bus command beat
  typedef struct packed {
    logic       start_request;
    logic       stop_request;
    logic       ack_disable;
    logic       irq_enable;
    logic       irq_disable;
    logic       tx_write;
    logic [7:0] tx_byte;
  } cmd_t;

  typedef logic [DECIMAL_DIGITS-1:0][3:0] digits_t;

  // Work handed from front to back end: a command, optionally with a message
  typedef struct packed {
    logic    is_msg;
    cmd_t    cmd;
    digits_t x_digits;
    digits_t y_digits;
  } job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Split a byte into hundreds, tens and ones by reciprocal multiplication
  function automatic digits_t to_decimal(logic [7:0] v);
    logic [15:0] p1;
    logic [15:0] p2;
    logic [4:0]  q1;
    logic [4:0]  q2;
    logic [7:0]  ones;
    logic [4:0]  tens;
    digits_t     d;
    p1   = {8'd0, v} * 16'd205;
    q1   = p1[15:11];
    ones = v - ({3'd0, q1} * 8'd10);
    p2   = {11'd0, q1} * 16'd205;
    q2   = p2[15:11];
    tens = q1 - 5'(q2 * 5'd10);
    d[2] = q2[3:0];
    d[1] = tens[3:0];
    d[0] = ones[3:0];
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_if: event and result channels of the register read sequencer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrs_evt_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       update_event;
  logic       compare_event;
  logic       start_sent;
  logic       address_sent;
  logic       byte_finished;
  logic       rx_not_empty;
  logic [7:0] rx_byte;

  modport source (
    output valid, op, update_event, compare_event, start_sent, address_sent,
           byte_finished, rx_not_empty, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, op, update_event, compare_event, start_sent, address_sent,
           byte_finished, rx_not_empty, rx_byte,
    output ready
  );
endinterface

interface rrs_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       start_request;
  logic       stop_request;
  logic       ack_disable;
  logic       irq_enable;
  logic       irq_disable;
  logic       tx_write;
  logic [7:0] tx_byte;
  logic [7:0] char_byte;
  logic       last;

  modport source (
    output valid, kind, start_request, stop_request, ack_disable, irq_enable,
           irq_disable, tx_write, tx_byte, char_byte, last,
    input  ready
  );
  modport sink (
    input  valid, kind, start_request, stop_request, ack_disable, irq_enable,
           irq_disable, tx_write, tx_byte, char_byte, last,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/rrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_front: event decoder and read sequencer state
// Accepts timer and controller status beats, advances the read sequence,
// captures received bytes and pushes one job per beat that has results.
// ----------------------------------------------------------------------------
module rrs_front
  import rrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  rrs_evt_if.sink         evt,
  input  wire qstat_t     qs,
  output logic            push,
  output job_t            push_job
);

  logic [6:0] device_address;
  logic [7:0] x_register;
  logic [7:0] y_register;

  phase_t     phase, phase_next;
  step_t      step, step_next;
  logic [7:0] target, target_next;
  logic [7:0] x_value, x_value_next;
  logic [7:0] y_value, y_value_next;
  logic       accept;

  assign evt.ready = !qs.full;
  assign accept    = evt.valid && evt.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      x_register     <= X_REGISTER_RST;
      y_register     <= Y_REGISTER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        CFG_X_REGISTER:     x_register     <= cfg_data;
        CFG_Y_REGISTER:     y_register     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      step    <= STP_START;
      target  <= '0;
      x_value <= '0;
      y_value <= '0;
    end else begin
      phase   <= phase_next;
      step    <= step_next;
      target  <= target_next;
      x_value <= x_value_next;
      y_value <= y_value_next;
    end
  end

  // Decode the beat, advance the sequence and build the job
  always_comb begin
    phase_next   = phase;
    step_next    = step;
    target_next  = target;
    x_value_next = x_value;
    y_value_next = y_value;
    push         = 1'b0;
    push_job     = '0;
    if (accept) begin
      if (!evt.op) begin
        if (evt.update_event || evt.compare_event) begin
          push                       = 1'b1;
          push_job.is_msg            = evt.compare_event;
          push_job.cmd.irq_enable    = 1'b1;
          push_job.cmd.start_request = 1'b1;
          push_job.x_digits          = to_decimal(x_value);
          push_job.y_digits          = to_decimal(y_value);
          target_next = evt.compare_event ? y_register : x_register;
          phase_next  = PH_WRITING;
          step_next   = STP_START;
        end
      end else begin
        case (phase)
          PH_WRITING: begin
            push = 1'b1;
            if (step == STP_START && evt.start_sent) begin
              step_next             = STP_ADDR_W;
              push_job.cmd.tx_write = 1'b1;
              push_job.cmd.tx_byte  = {device_address, 1'b0};
            end else if (step == STP_ADDR_W && evt.address_sent) begin
              step_next             = STP_REG_SENT;
              phase_next            = PH_READING;
              push_job.cmd.tx_write = 1'b1;
              push_job.cmd.tx_byte  = target;
            end else begin
              push_job.cmd.stop_request = 1'b1;
            end
          end
          PH_READING: begin
            if (step == STP_REG_SENT && evt.byte_finished) begin
              push                       = 1'b1;
              push_job.cmd.start_request = 1'b1;
              step_next                  = STP_RESTART;
            end else if (step == STP_RESTART && evt.start_sent) begin
              push                     = 1'b1;
              push_job.cmd.tx_write    = 1'b1;
              push_job.cmd.tx_byte     = {device_address, 1'b1};
              push_job.cmd.ack_disable = 1'b1;
              step_next                = STP_ADDR_R;
            end else if (step == STP_ADDR_R && evt.address_sent) begin
              push                      = 1'b1;
              push_job.cmd.stop_request = 1'b1;
              step_next                 = STP_DATA;
            end else if (step == STP_DATA && evt.rx_not_empty) begin
              if (target == x_register) begin
                x_value_next = evt.rx_byte;
              end else begin
                y_value_next = evt.rx_byte;
              end
              phase_next = PH_IDLE;
            end
          end
          default: begin
            push                      = 1'b1;
            push_job.cmd.stop_request = 1'b1;
            push_job.cmd.irq_disable  = 1'b1;
            step_next                 = STP_START;
            phase_next                = PH_IDLE;
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // Reading is only entered past the register number
  a_read_step: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READING) |-> (step >= STP_REG_SENT && step <= STP_DATA))
    else $error("reading phase with an early step");

  // Writing covers only the first two steps
  a_write_step: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WRITING) |-> (step == STP_START || step == STP_ADDR_W))
    else $error("writing phase with a late step");

  // A timer start always restarts the sequence
  a_timer_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !evt.op && (evt.update_event || evt.compare_event))
      |=> (phase == PH_WRITING && step == STP_START))
    else $error("timer start did not restart the read");
`endif

endmodule
`default_nettype wire

FILE: hdl/rrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_queue: job queue between front and back end
// Small first-word-fall-through FIFO; the head job is visible while not empty.
// ----------------------------------------------------------------------------
module rrs_queue
  import rrs_pkg::*;
#(
  parameter int DEPTH = RRS_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output qstat_t    qs
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qs.full  = (count == CNT_FULL);
  assign qs.empty = (count == '0);
  assign head     = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Fill count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  // Push never lands on a full queue, pop never on an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && qs.full) && !(pop && qs.empty))
    else $error("queue overrun or underrun");

  // A lone pop drains exactly one entry
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

FILE: hdl/rrs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_back: result beat generator
// Expands the head job into one command beat, followed for a message job by
// ten character beats, and pops the job on its last beat.
// ----------------------------------------------------------------------------
module rrs_back
  import rrs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire job_t   head,
  input  wire qstat_t qs,
  output logic        pop,
  rrs_res_if.source   res
);

  // Beat positions within a message job
  localparam logic [3:0] BEAT_CMD    = 4'd0;
  localparam logic [3:0] BEAT_X_TAG  = 4'd1;
  localparam logic [3:0] BEAT_X_HUND = 4'd2;
  localparam logic [3:0] BEAT_X_TENS = 4'd3;
  localparam logic [3:0] BEAT_X_ONES = 4'd4;
  localparam logic [3:0] BEAT_Y_TAG  = 4'd5;
  localparam logic [3:0] BEAT_Y_HUND = 4'd6;
  localparam logic [3:0] BEAT_Y_TENS = 4'd7;
  localparam logic [3:0] BEAT_Y_ONES = 4'd8;
  localparam logic [3:0] BEAT_CR     = 4'd9;
  localparam logic [3:0] BEAT_LF     = 4'd10;

  logic [3:0] beat;
  logic       last_beat;
  logic       out_accept;
  logic       is_char;
  cmd_t       cmd;

  assign last_beat  = head.is_msg ? (beat == BEAT_LF) : 1'b1;
  assign res.valid  = !qs.empty;
  assign out_accept = res.valid && res.ready;
  assign pop        = out_accept && last_beat;
  assign is_char    = head.is_msg && (beat != BEAT_CMD);

  // Count beats of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= BEAT_CMD;
    end else if (out_accept) begin
      beat <= last_beat ? BEAT_CMD : beat + 1'b1;
    end
  end

  // Select the character for this beat
  always_comb begin
    case (beat)
      BEAT_X_TAG:  res.char_byte = CHAR_X;
      BEAT_X_HUND: res.char_byte = CHAR_ZERO + {4'd0, head.x_digits[2]};
      BEAT_X_TENS: res.char_byte = CHAR_ZERO + {4'd0, head.x_digits[1]};
      BEAT_X_ONES: res.char_byte = CHAR_ZERO + {4'd0, head.x_digits[0]};
      BEAT_Y_TAG:  res.char_byte = CHAR_Y;
      BEAT_Y_HUND: res.char_byte = CHAR_ZERO + {4'd0, head.y_digits[2]};
      BEAT_Y_TENS: res.char_byte = CHAR_ZERO + {4'd0, head.y_digits[1]};
      BEAT_Y_ONES: res.char_byte = CHAR_ZERO + {4'd0, head.y_digits[0]};
      BEAT_CR:     res.char_byte = CHAR_CR;
      BEAT_LF:     res.char_byte = CHAR_LF;
      default:     res.char_byte = '0;
    endcase
    if (!is_char) begin
      res.char_byte = '0;
    end
  end

  // Command fields drop to zero on character beats
  assign cmd               = is_char ? '0 : head.cmd;
  assign res.kind          = is_char;
  assign res.start_request = cmd.start_request;
  assign res.stop_request  = cmd.stop_request;
  assign res.ack_disable   = cmd.ack_disable;
  assign res.irq_enable    = cmd.irq_enable;
  assign res.irq_disable   = cmd.irq_disable;
  assign res.tx_write      = cmd.tx_write;
  assign res.tx_byte       = cmd.tx_byte;
  assign res.last          = last_beat;

endmodule
`default_nettype wire

FILE: hdl/i2c_register_read_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_read_sequencer: I2C master register read sequencer
// Steps one-byte sensor register reads from timer and controller status
// events, and emits bus commands and an "X ddd Y ddd CR LF" message.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       contents
//  evt      in   valid/ready     op, timer flags, status flags, rx_byte
//  res      out  valid/ready     kind, command bits, tx_byte, char_byte, last
//  cfg      in   cfg_write only  cfg_index, cfg_data
//
//  An event beat is taken whenever the job queue has room.
//  Each result beat waits for res.ready: a command job is one beat and a
//  message job eleven. Events without results never enter the queue.
//  Synchronous reset clears sequencer state, queue and beat counter.
//  Stalls on res fill the queue, then drop evt.ready.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer
  import rrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = RRS_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  rrs_evt_if.sink         evt,
  rrs_res_if.source       res
);

  logic   push;
  logic   pop;
  job_t   push_job;
  job_t   head;
  qstat_t qs;

  rrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .qs        (qs),
    .push      (push),
    .push_job  (push_job)
  );

  rrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  rrs_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qs   (qs),
    .pop  (pop),
    .res  (res)
  );

endmodule
`default_nettype wire

FILE: verif/rrs_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_tb_pkg: testbench types for the register read sequencer
// Event codes and the layout of one event beat, shared by the stimulus
// side and the checker.
// ----------------------------------------------------------------------------
package rrs_tb_pkg;

  // Event kinds on the evt channel
  localparam logic OP_TIMER  = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  // Register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One event beat as the testbench sees it
  typedef struct packed {
    logic       op;
    logic       update_event;
    logic       compare_event;
    logic       start_sent;
    logic       address_sent;
    logic       byte_finished;
    logic       rx_not_empty;
    logic [7:0] rx_byte;
  } evt_t;

endpackage

FILE: verif/rrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_checker: result predictor and scoreboard for the register read sequencer
// Tracks register writes and accepted event beats, works out the command and
// message beats each event should cause, and compares them in order against
// the beats taken from the result channel.
// ----------------------------------------------------------------------------
module rrs_checker
  import rrs_pkg::*;
  import rrs_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  rrs_evt_if         evt,
  rrs_res_if         res,
  output int         fail_count,
  output int         outstanding
);

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_CHAR = 1'b1;
  localparam int   MAX_REPORTS = 10;

  typedef struct packed {
    logic       kind;
    cmd_t       cmd;
    logic [7:0] char_byte;
    logic       last;
  } beat_t;

  // Shadow configuration
  logic [6:0] dev_addr;
  logic [7:0] x_reg;
  logic [7:0] y_reg;

  // Shadow sequencer state
  phase_t     rd_phase;
  step_t      rd_step;
  logic [7:0] target_reg;
  logic [7:0] x_val;
  logic [7:0] y_val;

  beat_t      due_beats[$];
  int         mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic void push_cmd(cmd_t c, logic fin);
    beat_t b;
    b      = '0;
    b.kind = KIND_CMD;
    b.cmd  = c;
    b.last = fin;
    due_beats.push_back(b);
  endfunction

  function automatic void push_char(logic [7:0] c, logic fin);
    beat_t b;
    b           = '0;
    b.kind      = KIND_CHAR;
    b.char_byte = c;
    b.last      = fin;
    due_beats.push_back(b);
  endfunction

  // Tag letter followed by the value in fixed-width decimal
  function automatic void push_value(logic [7:0] tag, logic [7:0] v);
    logic [7:0] rest;
    logic [7:0] digs [DECIMAL_DIGITS];
    int         i;
    rest = v;
    for (i = DECIMAL_DIGITS - 1; i >= 0; i--) begin
      digs[i] = CHAR_ZERO + (rest % 8'd10);
      rest    = rest / 8'd10;
    end
    push_char(tag, 1'b0);
    for (i = 0; i < DECIMAL_DIGITS; i++) push_char(digs[i], 1'b0);
  endfunction

  // Advance the shadow sequencer by one event and queue the beats it causes
  function automatic void predict_event(evt_t e);
    cmd_t c;
    c = '0;
    if (e.op == OP_TIMER) begin
      if (!e.update_event && !e.compare_event) return;
      // a Y start overrides an X start in the same event
      if (e.update_event) target_reg = x_reg;
      if (e.compare_event) target_reg = y_reg;
      rd_phase        = PH_WRITING;
      rd_step         = STP_START;
      c.irq_enable    = 1'b1;
      c.start_request = 1'b1;
      push_cmd(c, !e.compare_event);
      if (e.compare_event) begin
        // message carries the values held before this event
        push_value(CHAR_X, x_val);
        push_value(CHAR_Y, y_val);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b1);
      end
      return;
    end
    case (rd_phase)
      PH_WRITING: begin
        if (rd_step == STP_START && e.start_sent) begin
          rd_step    = STP_ADDR_W;
          c.tx_write = 1'b1;
          c.tx_byte  = {dev_addr, 1'b0};
        end else if (rd_step == STP_ADDR_W && e.address_sent) begin
          rd_step    = STP_REG_SENT;
          rd_phase   = PH_READING;
          c.tx_write = 1'b1;
          c.tx_byte  = target_reg;
        end else begin
          c.stop_request = 1'b1;
        end
        push_cmd(c, 1'b1);
      end
      PH_READING: begin
        if (rd_step == STP_REG_SENT && e.byte_finished) begin
          rd_step         = STP_RESTART;
          c.start_request = 1'b1;
          push_cmd(c, 1'b1);
        end else if (rd_step == STP_RESTART && e.start_sent) begin
          rd_step       = STP_ADDR_R;
          c.tx_write    = 1'b1;
          c.tx_byte     = {dev_addr, 1'b1};
          c.ack_disable = 1'b1;
          push_cmd(c, 1'b1);
        end else if (rd_step == STP_ADDR_R && e.address_sent) begin
          rd_step        = STP_DATA;
          c.stop_request = 1'b1;
          push_cmd(c, 1'b1);
        end else if (rd_step == STP_DATA && e.rx_not_empty) begin
          // equal register numbers favour X; step stays put
          if (target_reg == x_reg) x_val = e.rx_byte;
          else y_val = e.rx_byte;
          rd_phase = PH_IDLE;
        end
      end
      default: begin
        // status while idle: abort and silence the controller
        rd_step        = STP_START;
        rd_phase       = PH_IDLE;
        c.stop_request = 1'b1;
        c.irq_disable  = 1'b1;
        push_cmd(c, 1'b1);
      end
    endcase
  endfunction

  function automatic string describe(beat_t b);
    return $sformatf({"kind %0d start %0d stop %0d ackdis %0d irqen %0d irqdis %0d",
                      " txw %0d tx %02h char %02h last %0d"},
                     b.kind, b.cmd.start_request, b.cmd.stop_request,
                     b.cmd.ack_disable, b.cmd.irq_enable, b.cmd.irq_disable,
                     b.cmd.tx_write, b.cmd.tx_byte, b.char_byte, b.last);
  endfunction

  // Watch both channels and the register port on every edge
  always @(posedge clk) begin : watch
    beat_t got;
    beat_t want;
    evt_t  ev;
    if (rst) begin
      dev_addr   = DEVICE_ADDRESS_RST;
      x_reg      = X_REGISTER_RST;
      y_reg      = Y_REGISTER_RST;
      rd_phase   = PH_IDLE;
      rd_step    = STP_START;
      target_reg = '0;
      x_val      = '0;
      y_val      = '0;
      due_beats.delete();
    end else begin
      // compare a result beat against the oldest prediction
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        got.kind              = res.kind;
        got.cmd.start_request = res.start_request;
        got.cmd.stop_request  = res.stop_request;
        got.cmd.ack_disable   = res.ack_disable;
        got.cmd.irq_enable    = res.irq_enable;
        got.cmd.irq_disable   = res.irq_disable;
        got.cmd.tx_write      = res.tx_write;
        got.cmd.tx_byte       = res.tx_byte;
        got.char_byte         = res.char_byte;
        got.last              = res.last;
        if (due_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing predicted: %s", $realtime,
                     describe(got));
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: result beat mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (evt.valid === 1'b1 && evt.ready === 1'b1) begin
        ev.op            = evt.op;
        ev.update_event  = evt.update_event;
        ev.compare_event = evt.compare_event;
        ev.start_sent    = evt.start_sent;
        ev.address_sent  = evt.address_sent;
        ev.byte_finished = evt.byte_finished;
        ev.rx_not_empty  = evt.rx_not_empty;
        ev.rx_byte       = evt.rx_byte;
        predict_event(ev);
      end
      // register writes take effect after any event taken on the same edge
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_addr = cfg_data[6:0];
          CFG_X_REGISTER:     x_reg    = cfg_data;
          CFG_Y_REGISTER:     y_reg    = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count  <= mismatches + due_beats.size();
    outstanding <= due_beats.size();
  end

endmodule

FILE: verif/tb_i2c_register_read_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_read_sequencer: top-level testbench for the read sequencer
// Drives timer and bus status events through four register settings: a
// directed pass over the special cases, then mostly well-formed register
// reads with random content mixed with noise and abandoned reads. Idling on
// both channels varies by phase; a checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_i2c_register_read_sequencer;
  import rrs_pkg::*;
  import rrs_tb_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int TIMEOUT_NS    = 400_000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int outstanding;

  int tx_idle_pct = 14;
  int rx_idle_pct = 85;
  int hold_seq    = 0;

  int counted    = 0;
  int full_reads = 0;
  int messages   = 0;

  rrs_evt_if evt_ch ();
  rrs_res_if res_ch ();

  i2c_register_read_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch.sink),
    .res       (res_ch.source)
  );

  rrs_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .evt         (evt_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("tb_i2c_register_read_sequencer: done, errors");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off when asked
  initial begin : rx_side
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic evt_t mk_evt(logic op, int upd, int cmp, int sb,
                                  int addr, int btf, int rxne,
                                  logic [7:0] rx);
    evt_t e;
    e = {op, 1'(upd), 1'(cmp), 1'(sb), 1'(addr), 1'(btf), 1'(rxne), rx};
    return e;
  endfunction

  function automatic evt_t rand_evt();
    evt_t e;
    e.op            = 1'($urandom_range(1));
    e.update_event  = 1'($urandom_range(1));
    e.compare_event = 1'($urandom_range(1));
    e.start_sent    = 1'($urandom_range(1));
    e.address_sent  = 1'($urandom_range(1));
    e.byte_finished = 1'($urandom_range(1));
    e.rx_not_empty  = 1'($urandom_range(1));
    e.rx_byte       = 8'($urandom_range(255));
    return e;
  endfunction

  // Status beat for a given read step; hit picks whether its flag is set
  function automatic evt_t step_item(int s, logic hit);
    evt_t e;
    e    = rand_evt();
    e.op = OP_STATUS;
    case (step_t'(s))
      STP_START, STP_RESTART: e.start_sent   = hit;
      STP_ADDR_W, STP_ADDR_R: e.address_sent = hit;
      STP_REG_SENT:           e.byte_finished = hit;
      default:                e.rx_not_empty = hit;
    endcase
    return e;
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and hold until taken
  task automatic send_event(input evt_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    evt_ch.valid         <= 1'b1;
    evt_ch.op            <= e.op;
    evt_ch.update_event  <= e.update_event;
    evt_ch.compare_event <= e.compare_event;
    evt_ch.start_sent    <= e.start_sent;
    evt_ch.address_sent  <= e.address_sent;
    evt_ch.byte_finished <= e.byte_finished;
    evt_ch.rx_not_empty  <= e.rx_not_empty;
    evt_ch.rx_byte       <= e.rx_byte;
    do @(posedge clk); while (evt_ch.ready !== 1'b1);
    // a timer beat with no flag is dropped by the block
    if (e.op != OP_TIMER || e.update_event || e.compare_event) counted++;
    if (e.op == OP_TIMER && e.compare_event) messages++;
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain();
    evt_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [6:0] addr, input logic [7:0] xr,
                            input logic [7:0] yr);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_data  <= {1'($urandom_range(1)), addr};
    @(posedge clk);
    cfg_index <= CFG_X_REGISTER;
    cfg_data  <= xr;
    @(posedge clk);
    cfg_index <= CFG_Y_REGISTER;
    cfg_data  <= yr;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Timer start, then the status beats up to upto, with stray beats mixed in
  task automatic read_sequence(input int upto);
    evt_t e;
    int   which;
    int   s;
    e     = rand_evt();
    e.op  = OP_TIMER;
    which = $urandom_range(2);
    e.update_event  = (which != 1);
    e.compare_event = (which != 0);
    send_event(e);
    for (s = 0; s <= upto; s++) begin
      if ($urandom_range(9) == 0) send_event(step_item(s, 1'b0));
      send_event(step_item(s, 1'b1));
    end
    if (upto == int'(STP_DATA)) full_reads++;
  endtask

  task automatic run_random(input int n);
    int goal;
    int pick;
    goal = counted + n;
    while (counted < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) read_sequence(int'(STP_DATA));
      else if (pick < 85) send_event(rand_evt());
      else read_sequence($urandom_range(int'(STP_ADDR_R)));
    end
  endtask

  initial begin : stimulus
    logic [7:0] same_reg;
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = CFG_DEVICE_ADDRESS;
    cfg_data             = '0;
    evt_ch.valid         = 1'b0;
    evt_ch.op            = OP_TIMER;
    evt_ch.update_event  = 1'b0;
    evt_ch.compare_event = 1'b0;
    evt_ch.start_sent    = 1'b0;
    evt_ch.address_sent  = 1'b0;
    evt_ch.byte_finished = 1'b0;
    evt_ch.rx_not_empty  = 1'b0;
    evt_ch.rx_byte       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass on reset register values
    send_event(mk_evt(OP_STATUS, 1, 1, 1, 1, 1, 1, 8'hFF)); // status while idle
    send_event(mk_evt(OP_TIMER, 0, 0, 0, 0, 0, 0, 8'h00));  // no timer flag
    send_event(mk_evt(OP_TIMER, 0, 1, 0, 0, 0, 0, 8'h00));  // message of zeros
    // full read of X, top byte value
    send_event(mk_evt(OP_TIMER, 1, 0, 0, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 0, 1, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 0, 0, 1, 8'hFF));
    // both timer flags: Y wins
    send_event(mk_evt(OP_TIMER, 1, 1, 0, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 0, 1, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 0, 0, 1, 8'h09));
    // wrong flags while writing and while reading
    send_event(mk_evt(OP_TIMER, 1, 0, 0, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 0, 0, 1, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 0, 1, 0, 0, 8'h00));
    send_event(mk_evt(OP_STATUS, 0, 0, 1, 0, 0, 0, 8'h00));
    send_event(mk_evt(OP_TIMER, 0, 1, 0, 0, 0, 0, 8'h00));  // message of stored values
    drain();

    // Top address, register numbers at the extremes; slow receiver
    write_regs(7'd127, 8'd0, 8'd255);
    run_random(100);
    drain();

    // Other extremes; slow sender
    tx_idle_pct = 85;
    rx_idle_pct = 14;
    write_regs(7'd0, 8'd255, 8'd0);
    run_random(100);
    drain();

    // Equal X and Y register numbers; no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    same_reg    = 8'($urandom_range(255));
    write_regs(7'($urandom_range(127)), same_reg, same_reg);
    run_random(90);
    drain();

    // Random registers; long receiver hold-off, then a full pause
    write_regs(7'($urandom_range(127)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    hold_seq <= hold_seq + 1;
    run_random(50);
    drain();
    run_random(50);
    drain();

    $display("Covered %0d events: %0d complete reads, %0d message starts.",
             counted, full_reads, messages);
    $display("Four register settings, idle mixes on both sides, one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_i2c_register_read_sequencer: done, clean");
    end else begin
      $display("tb_i2c_register_read_sequencer: done, errors");
    end
    $finish;
  end

endmodule
